/* design/fixed_block_pool_allocator_macros.svh */
// assertion shorthands, clocked on clk and held off during reset
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// condition holds at every edge
`define FBPA_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds at the same edge
`define FBPA_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds at the following edge
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/fbpa_pkg.sv */
package fbpa_pkg;

	localparam int MAX_BLOCKS_DEF = 256;
	localparam int INDEX_CAP      = 256;
	localparam int IDX_W          = 8;
	localparam int CNT_W          = 9;
	localparam int STRIDE_W       = 16;
	localparam int OFFS_W         = 24;
	localparam int WORD_W         = 32;
	localparam int BIT_W          = 5;
	localparam int CFG_DATA_W     = 16;

	localparam logic [CNT_W-1:0]    BLOCK_COUNT_RST  = 9'd256;
	localparam logic [STRIDE_W-1:0] BLOCK_STRIDE_RST = 16'd64;

	localparam logic MARK_FREE = 1'b0;
	localparam logic MARK_USED = 1'b1;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_GRANTED  = 2'd0,
		STAT_OVERFLOW = 2'd1,
		STAT_FREED    = 2'd2,
		STAT_INVALID  = 2'd3
	} status_t;

	typedef enum logic {
		CFG_BLOCK_COUNT  = 1'b0,
		CFG_BLOCK_STRIDE = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_RESP
	} pool_state_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] bit_idx;
	} scan_hit_t;

endpackage

/* design/fbpa_if.sv */
interface fbpa_req_if;
	import fbpa_pkg::*;
	logic             valid;
	logic             ready;
	logic             opcode;
	logic [IDX_W-1:0] free_index;
	logic             free_is_overflow;
	modport source (output valid, opcode, free_index, free_is_overflow, input ready);
	modport sink (input valid, opcode, free_index, free_is_overflow, output ready);
endinterface

interface fbpa_rsp_if;
	import fbpa_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [IDX_W-1:0]  granted_index;
	logic [OFFS_W-1:0] byte_offset;
	modport source (output valid, status, granted_index, byte_offset, input ready);
	modport sink (input valid, status, granted_index, byte_offset, output ready);
endinterface

interface fbpa_cfg_if;
	import fbpa_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/fbpa_mark_ram.sv */
module fbpa_mark_ram #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [fbpa_pkg::WORD_W-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [fbpa_pkg::WORD_W-1:0] wr_data
);
	import fbpa_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [WORD_W-1:0] rd_data_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// a word never written since reset reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

/* design/fbpa_scan.sv */
module fbpa_scan #(
	parameter int WADDR_W = 3
) (
	input  logic [fbpa_pkg::WORD_W-1:0] marks,
	input  logic [WADDR_W-1:0]          word,
	input  logic [fbpa_pkg::CNT_W-1:0]  lo,
	input  logic [fbpa_pkg::CNT_W-1:0]  hi,
	output fbpa_pkg::scan_hit_t         hit
);
	import fbpa_pkg::*;

	logic [WORD_W-1:0] cand;

	// free and inside [lo, hi)
	always_comb begin
		logic [CNT_W-1:0] pos;
		cand = '0;
		for (int b = 0; b < WORD_W; b++) begin
			pos     = CNT_W'({word, BIT_W'(b)});
			cand[b] = (marks[b] == MARK_FREE) && (pos >= lo) && (pos < hi);
		end
	end

	// lowest candidate wins
	always_comb begin
		hit = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (cand[b]) begin
				hit.found   = 1'b1;
				hit.bit_idx = BIT_W'(b);
			end
		end
	end

endmodule

/* design/fixed_block_pool_allocator.sv */
// Fixed-size block pool allocator, first fit from a search hint. The used marks of the pool
// live in one single-port-style memory of 32-bit words (32 blocks per word), each word
// backed by a valid flop so that reset frees the whole pool at once with no clearing pass.
// An allocate beat scans upward from the hint one word at a time (memory read, then
// evaluate and write back), looking at 1 to 8 words for a 256-block pool, and answers
// overflow with no scan when the hint already sits at or past the pool limit. A free
// beat goes through accept, read, write back and respond. One request is in
// work at a time; the response register lets a result wait for the sink while the block
// returns to idle. Freed blocks are named by index; a free of an overflow block only
// answers freed, and a free at or past the pool limit answers invalid and is dropped.
`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fbpa_cfg_if.sink    cfg,
	fbpa_req_if.sink    req,
	fbpa_rsp_if.source  rsp
);
	import fbpa_pkg::*;

	// blocks that can ever be addressed, capped by the 8-bit index
	localparam int POOL_CAP  = (MAX_BLOCKS < INDEX_CAP) ? MAX_BLOCKS : INDEX_CAP;
	localparam int MEM_WORDS = (POOL_CAP + WORD_W - 1) / WORD_W;
	localparam int WADDR_W   = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

	// configuration
	logic [CNT_W-1:0]    block_count_q;
	logic [STRIDE_W-1:0] block_stride_q;

	// control
	pool_state_t      state_q, state_d;
	logic [CNT_W-1:0] hint_q;
	logic             rsp_valid_q;

	// request in work
	opcode_t           op_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [WADDR_W-1:0] word_q;
	status_t           res_status_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic [OFFS_W-1:0] res_offs_q;

	// response register
	status_t           rsp_status_q;
	logic [IDX_W-1:0]  rsp_idx_q;
	logic [OFFS_W-1:0] rsp_offs_q;

	// fsm outputs
	logic              req_ready;
	logic              rd_en;
	logic              wr_en;
	logic [WORD_W-1:0] wr_data;
	logic              load_rsp;

	logic [WORD_W-1:0] rd_data;
	scan_hit_t         hit;
	logic [CNT_W-1:0]  lim;
	logic [CNT_W-1:0]  next_base;
	logic              last_word;
	logic [IDX_W-1:0]  grant_idx;
	logic [OFFS_W-1:0] grant_offs;
	logic              req_fire;
	logic              req_bad_free;

	// effective pool size: configured count clamped to what the memory holds
	assign lim = (block_count_q > CNT_W'(POOL_CAP)) ? CNT_W'(POOL_CAP) : block_count_q;

	assign req_fire     = req.valid && req_ready;
	assign req_bad_free = (CNT_W'(req.free_index) >= lim);

	// first index of the following word; scan ends once it reaches the limit
	assign next_base = CNT_W'({word_q, BIT_W'(0)}) + CNT_W'(WORD_W);
	assign last_word = (next_base >= lim);

	assign grant_idx  = IDX_W'({word_q, hit.bit_idx});
	assign grant_offs = OFFS_W'(grant_idx) * OFFS_W'(block_stride_q);

	fbpa_mark_ram #(
		.DEPTH (MEM_WORDS),
		.AW    (WADDR_W)
	) u_marks (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (word_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (word_q),
		.wr_data (wr_data)
	);

	fbpa_scan #(
		.WADDR_W (WADDR_W)
	) u_scan (
		.marks (rd_data),
		.word  (word_q),
		.lo    (hint_q),
		.hi    (lim),
		.hit   (hit)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control outputs
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		wr_data   = rd_data;
		load_rsp  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					if (opcode_t'(req.opcode) == OP_ALLOC) begin
						// hint at or past the limit: overflow with no scan
						state_d = (hint_q < lim) ? ST_READ : ST_RESP;
					end else if (req.free_is_overflow || req_bad_free) begin
						state_d = ST_RESP;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (op_q == OP_FREE) begin
					wr_en                               = 1'b1;
					wr_data[free_idx_q[BIT_W-1:0]]      = MARK_FREE;
					state_d                             = ST_RESP;
				end else if (hit.found) begin
					wr_en                 = 1'b1;
					wr_data[hit.bit_idx]  = MARK_USED;
					state_d               = ST_RESP;
				end else if (last_word) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// config registers, hint and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q  <= BLOCK_COUNT_RST;
			block_stride_q <= BLOCK_STRIDE_RST;
			hint_q         <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg_idx_t'(cfg.index))
					CFG_BLOCK_COUNT:  block_count_q  <= cfg.data[CNT_W-1:0];
					CFG_BLOCK_STRIDE: block_stride_q <= cfg.data[STRIDE_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == ST_EVAL) begin
				if (op_q == OP_FREE) begin
					// freeing below the hint pulls it down
					if (CNT_W'(free_idx_q) < hint_q) begin
						hint_q <= CNT_W'(free_idx_q);
					end
				end else if (hit.found) begin
					hint_q <= CNT_W'(grant_idx) + CNT_W'(1);
				end
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request payload, scan position and result
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q       <= opcode_t'(req.opcode);
			free_idx_q <= req.free_index;
			res_idx_q  <= '0;
			res_offs_q <= '0;
			if (opcode_t'(req.opcode) == OP_ALLOC) begin
				word_q       <= hint_q[BIT_W +: WADDR_W];
				res_status_q <= STAT_OVERFLOW;
			end else begin
				word_q <= req.free_index[BIT_W +: WADDR_W];
				if (req.free_is_overflow) begin
					res_status_q <= STAT_FREED;
				end else if (req_bad_free) begin
					res_status_q <= STAT_INVALID;
				end else begin
					res_status_q <= STAT_FREED;
				end
			end
		end
		if (state_q == ST_EVAL && op_q == OP_ALLOC) begin
			if (hit.found) begin
				res_status_q <= STAT_GRANTED;
				res_idx_q    <= grant_idx;
				res_offs_q   <= grant_offs;
			end else if (!last_word) begin
				word_q <= WADDR_W'(word_q + 1'b1);
			end
		end
		if (load_rsp) begin
			rsp_status_q <= res_status_q;
			rsp_idx_q    <= res_idx_q;
			rsp_offs_q   <= res_offs_q;
		end
	end

	assign req.ready         = req_ready;
	assign cfg.ready         = 1'b1;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.granted_index = rsp_idx_q;
	assign rsp.byte_offset   = rsp_offs_q;

	`FBPA_ASSERT_HOLDS(a_hint_range, hint_q <= CNT_W'(INDEX_CAP), "search hint beyond pool")
	`FBPA_ASSERT_IMPLIES(a_grant_in_pool, rsp.valid && rsp.status == STAT_GRANTED, CNT_W'(rsp.granted_index) < lim, "granted block outside pool")
	`FBPA_ASSERT_IMPLIES(a_grant_offset, rsp.valid && rsp.status == STAT_GRANTED, rsp.byte_offset == OFFS_W'(rsp.granted_index) * OFFS_W'(block_stride_q), "byte offset does not match grant")
	`FBPA_ASSERT_IMPLIES(a_nogrant_zero, rsp.valid && rsp.status != STAT_GRANTED, rsp.granted_index == '0 && rsp.byte_offset == '0, "non-grant beat carries index or offset")
	`FBPA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, state_q != ST_IDLE, "request accepted but fsm stayed idle")

endmodule

/* tb/fixed_block_pool_allocator_tb.sv */
`timescale 1ns / 100ps

// allocator testbench: a directed script of requests and register writes, then random
// phases over several pool sizes and strides; every result beat is checked against a typed
// expectation or a local first-fit pool model fed in the order request beats are accepted
module fixed_block_pool_allocator_tb;
	import fbpa_pkg::*;

	// one expected or observed result beat
	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] index;
		logic [OFFS_W-1:0] offset;
	} pool_result_t;

	// one line of the directed script: either a register write or a request
	typedef struct {
		bit                    is_write;
		cfg_idx_t              reg_sel;
		logic [CFG_DATA_W-1:0] wdata;
		opcode_t               op;
		logic [IDX_W-1:0]      idx;
		logic                  ovf;
		bit                    typed;
		pool_result_t          want;
	} script_row_t;

	logic clk;
	logic arst_n;

	fbpa_cfg_if cfg_bus ();
	fbpa_req_if req_bus ();
	fbpa_rsp_if rsp_bus ();

	fixed_block_pool_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// model of the pool: used marks, search hint and the two registers
	bit                  pool_used [INDEX_CAP];
	logic [CNT_W-1:0]    pool_hint;
	logic [CNT_W-1:0]    pool_count;
	logic [STRIDE_W-1:0] pool_stride;

	pool_result_t pending_results [$];
	script_row_t  script [$];
	int           mismatch_count;
	bit           calm_mode;

	always #2 clk = ~clk;

	// hard stop, far past the slowest legal run
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report(string msg);
		$display("%0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// scan limit: register value clamped to the pool size
	function automatic int pool_limit();
		return (pool_count > INDEX_CAP) ? INDEX_CAP : int'(pool_count);
	endfunction

	// first fit from the hint for an allocate, mark clear and hint lowering for a free
	function automatic pool_result_t pool_serve(opcode_t op, logic [IDX_W-1:0] idx,
			logic ovf);
		pool_result_t res;
		int lim;
		lim = pool_limit();
		res = '{STAT_OVERFLOW, '0, '0};
		if (op == OP_ALLOC) begin
			for (int i = int'(pool_hint); i < lim; i++) begin
				if (pool_used[i] == MARK_FREE) begin
					pool_used[i] = MARK_USED;
					pool_hint = CNT_W'(i + 1);
					res.status = STAT_GRANTED;
					res.index = IDX_W'(i);
					res.offset = OFFS_W'(i * int'(pool_stride));
					break;
				end
			end
		end else if (ovf) begin
			// overflow blocks never lived in the pool
			res.status = STAT_FREED;
		end else if (int'(idx) >= lim) begin
			res.status = STAT_INVALID;
		end else begin
			// freeing a block that is already free still lowers the hint
			pool_used[idx] = MARK_FREE;
			if (pool_hint > idx)
				pool_hint = CNT_W'(idx);
			res.status = STAT_FREED;
		end
		return res;
	endfunction

	// a used block below the limit when one turns up quickly, else any index
	function automatic logic [IDX_W-1:0] pick_used_block();
		int lim;
		int k;
		lim = pool_limit();
		for (int t = 0; t < 16 && lim > 0; t++) begin
			k = $urandom_range(0, lim - 1);
			if (pool_used[k] == MARK_USED)
				return IDX_W'(k);
		end
		return IDX_W'($urandom_range(0, 255));
	endfunction

	// empty script line
	function automatic script_row_t blank_row();
		script_row_t r;
		r.is_write = 1'b0;
		r.reg_sel = CFG_BLOCK_COUNT;
		r.wdata = '0;
		r.op = OP_ALLOC;
		r.idx = '0;
		r.ovf = 1'b0;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	// script builders
	function automatic void row_write(cfg_idx_t sel, logic [CFG_DATA_W-1:0] data);
		script_row_t r;
		r = blank_row();
		r.is_write = 1'b1;
		r.reg_sel = sel;
		r.wdata = data;
		script.push_back(r);
	endfunction

	function automatic void row_req(opcode_t op, logic [IDX_W-1:0] idx, logic ovf);
		script_row_t r;
		r = blank_row();
		r.op = op;
		r.idx = idx;
		r.ovf = ovf;
		script.push_back(r);
	endfunction

	function automatic void row_typed(opcode_t op, logic [IDX_W-1:0] idx, logic ovf,
			status_t st, logic [IDX_W-1:0] gidx, logic [OFFS_W-1:0] offs);
		script_row_t r;
		r = blank_row();
		r.op = op;
		r.idx = idx;
		r.ovf = ovf;
		r.typed = 1'b1;
		r.want = '{st, gidx, offs};
		script.push_back(r);
	endfunction

	// one request beat; valid stays high after acceptance so the next beat can follow
	task automatic send_req(opcode_t op, logic [IDX_W-1:0] idx, logic ovf, bit typed,
			pool_result_t want);
		pool_result_t model_res;
		@(negedge clk);
		req_bus.valid <= 1'b1;
		req_bus.opcode <= op;
		req_bus.free_index <= idx;
		req_bus.free_is_overflow <= ovf;
		do @(posedge clk); while (!req_bus.ready);
		// the model always advances, even where the expectation is typed in
		model_res = pool_serve(op, idx, ovf);
		pending_results.push_back(typed ? want : model_res);
	endtask

	// sender gap with valid held low, sized by n
	task automatic hold_off(int n);
		@(negedge clk);
		req_bus.valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// register beat, only with the pool idle: every expected result already seen
	task automatic write_reg(cfg_idx_t sel, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= sel;
		cfg_bus.data <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		if (sel == CFG_BLOCK_COUNT)
			pool_count = data[CNT_W-1:0];
		else
			pool_stride = data[STRIDE_W-1:0];
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// result sink: random stall bursts between runs of ready, none in calm mode
	always @(negedge clk) begin
		static int burst_left = 0;
		if (calm_mode) begin
			rsp_bus.ready <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
		end else if ($urandom_range(0, 9) < 3) begin
			rsp_bus.ready <= 1'b0;
			burst_left = $urandom_range(0, 9);
		end else begin
			rsp_bus.ready <= 1'b1;
			burst_left = $urandom_range(0, 19);
		end
	end

	// result checker: each beat against the oldest expectation, field by field
	always @(posedge clk) begin
		pool_result_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_results.size() == 0) begin
				report($sformatf("result beat with nothing expected: status %0d index %0d",
					rsp_bus.status, rsp_bus.granted_index));
			end else begin
				want = pending_results.pop_front();
				if (rsp_bus.status !== want.status)
					report($sformatf("status %0d, expected %0d", rsp_bus.status,
						want.status));
				if (rsp_bus.granted_index !== want.index)
					report($sformatf("granted_index %0d, expected %0d",
						rsp_bus.granted_index, want.index));
				if (rsp_bus.byte_offset !== want.offset)
					report($sformatf("byte_offset %0d, expected %0d",
						rsp_bus.byte_offset, want.offset));
			end
		end
	end

	initial begin
		// random phases: pool size, stride, beats, percent of allocates
		int           ph_count [6] = '{256, 1, 256, 16'hFFFF, 37, 300};
		int           ph_stride [6] = '{64, 1, 65535, 0, 0, 0};
		int           ph_items [6] = '{120, 60, 300, 80, 120, 120};
		int           ph_alloc [6] = '{60, 50, 90, 35, 55, 50};
		script_row_t  r;
		opcode_t      op;
		logic [IDX_W-1:0] idx;
		logic         ovf;
		int           roll;

		clk = 1'b0;
		arst_n = 1'b0;
		calm_mode = 1'b0;
		mismatch_count = 0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_BLOCK_COUNT;
		cfg_bus.data = '0;
		req_bus.valid = 1'b0;
		req_bus.opcode = OP_ALLOC;
		req_bus.free_index = '0;
		req_bus.free_is_overflow = 1'b0;
		rsp_bus.ready = 1'b0;

		// model state after reset: pool all free, count 256, stride 64
		foreach (pool_used[i])
			pool_used[i] = MARK_FREE;
		pool_hint = '0;
		pool_count = BLOCK_COUNT_RST;
		pool_stride = BLOCK_STRIDE_RST;

		// directed script, straight from reset defaults
		row_typed(OP_ALLOC, 8'd0, 1'b0, STAT_GRANTED, 8'd0, 24'd0);
		row_typed(OP_ALLOC, 8'd0, 1'b0, STAT_GRANTED, 8'd1, 24'd64);
		row_typed(OP_FREE, 8'd0, 1'b0, STAT_FREED, 8'd0, 24'd0);
		// hint dropped back to the freed block
		row_typed(OP_ALLOC, 8'd0, 1'b0, STAT_GRANTED, 8'd0, 24'd0);
		row_typed(OP_ALLOC, 8'hFF, 1'b1, STAT_GRANTED, 8'd2, 24'd128);
		// overflow free is answered without touching the pool
		row_typed(OP_FREE, 8'd255, 1'b1, STAT_FREED, 8'd0, 24'd0);
		// free of a block that was never taken
		row_typed(OP_FREE, 8'd255, 1'b0, STAT_FREED, 8'd0, 24'd0);
		row_typed(OP_FREE, 8'd1, 1'b0, STAT_FREED, 8'd0, 24'd0);
		// single-block pool with the widest stride; hint already at the limit
		row_write(CFG_BLOCK_COUNT, 16'd1);
		row_write(CFG_BLOCK_STRIDE, 16'hFFFF);
		row_typed(OP_ALLOC, 8'd0, 1'b0, STAT_OVERFLOW, 8'd0, 24'd0);
		row_typed(OP_FREE, 8'd1, 1'b0, STAT_INVALID, 8'd0, 24'd0);
		row_typed(OP_FREE, 8'd0, 1'b0, STAT_FREED, 8'd0, 24'd0);
		row_typed(OP_ALLOC, 8'd0, 1'b0, STAT_GRANTED, 8'd0, 24'd0);
		row_typed(OP_ALLOC, 8'd0, 1'b0, STAT_OVERFLOW, 8'd0, 24'd0);
		// empty pool: every allocate overflows, every index is out of range
		row_write(CFG_BLOCK_COUNT, 16'd0);
		row_typed(OP_ALLOC, 8'd0, 1'b0, STAT_OVERFLOW, 8'd0, 24'd0);
		row_typed(OP_FREE, 8'd0, 1'b0, STAT_INVALID, 8'd0, 24'd0);
		row_typed(OP_FREE, 8'd0, 1'b1, STAT_FREED, 8'd0, 24'd0);
		// count past the pool size clamps to 256; zero stride gives offset zero
		row_write(CFG_BLOCK_COUNT, 16'hFFFF);
		row_write(CFG_BLOCK_STRIDE, 16'd0);
		row_typed(OP_ALLOC, 8'd0, 1'b0, STAT_GRANTED, 8'd1, 24'd0);
		row_req(OP_ALLOC, 8'd0, 1'b0);
		row_write(CFG_BLOCK_STRIDE, 16'hFFFF);
		row_req(OP_FREE, 8'd255, 1'b0);
		row_req(OP_ALLOC, 8'hAA, 1'b1);
		row_req(OP_FREE, 8'd128, 1'b1);
		row_req(OP_FREE, 8'd3, 1'b0);

		// reset held low first, then released away from the active edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[n]) begin
			r = script[n];
			if (r.is_write)
				write_reg(r.reg_sel, r.wdata);
			else
				send_req(r.op, r.idx, r.ovf, r.typed, r.want);
		end

		// random phases; the pool state carries over from one phase to the next
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'(ph_count[ph]));
			write_reg(CFG_BLOCK_STRIDE, (ph >= 4) ? CFG_DATA_W'($urandom_range(1, 65535)) :
				CFG_DATA_W'(ph_stride[ph]));
			// last phase runs with no gaps on either side
			if (ph == 5)
				calm_mode = 1'b1;
			for (int k = 0; k < ph_items[ph]; k++) begin
				roll = $urandom_range(0, 99);
				idx = IDX_W'($urandom_range(0, 255));
				ovf = 1'($urandom_range(0, 1));
				if (roll < ph_alloc[ph]) begin
					// index and overflow flag are don't-care on an allocate
					op = OP_ALLOC;
				end else begin
					op = OP_FREE;
					roll = $urandom_range(0, 9);
					if (roll == 0)
						ovf = 1'b1;
					else if (roll <= 2)
						ovf = 1'b0;
					else begin
						// well-formed free of a block handed out earlier
						ovf = 1'b0;
						idx = pick_used_block();
					end
				end
				if (!calm_mode && $urandom_range(0, 3) == 0)
					hold_off($urandom_range(1, 10));
				send_req(op, idx, ovf, 1'b0, '0);
			end
		end

		// drain, then let a last beat of a slow scan show up if one is stray
		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
